// ===== rtl/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared constants and helpers for the infix to postfix converter: character
// codes, operator encoding, precedence and default stack depth.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

   // Character codes
   localparam logic [7:0] CHAR_LOW_A = 8'd97;
   localparam logic [7:0] CHAR_LOW_Z = 8'd122;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_NONE  = 8'd0;

   // Stacked operator encoding; bit 1 set means high precedence
   localparam int unsigned OP_W = 2;
   typedef logic [OP_W-1:0] op_code_type;
   localparam op_code_type OP_ADD = 2'd0;
   localparam op_code_type OP_SUB = 2'd1;
   localparam op_code_type OP_MUL = 2'd2;
   localparam op_code_type OP_DIV = 2'd3;

   localparam int unsigned STACK_DEPTH_DEFAULT = 16;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
             (c == CHAR_SLASH);
   endfunction

   function automatic op_code_type op_code_of(input logic [7:0] c);
      op_code_type code;
      case (c)
         CHAR_PLUS:  code = OP_ADD;
         CHAR_MINUS: code = OP_SUB;
         CHAR_STAR:  code = OP_MUL;
         default:    code = OP_DIV;
      endcase
      return code;
   endfunction

   // Precedence: 1 for '*' and '/', 0 for '+' and '-'
   function automatic logic op_rank(input op_code_type code);
      return code[1];
   endfunction

   function automatic logic [7:0] op_char(input op_code_type code);
      logic [7:0] ch;
      unique case (code)
         OP_ADD:  ch = CHAR_PLUS;
         OP_SUB:  ch = CHAR_MINUS;
         OP_MUL:  ch = CHAR_STAR;
         OP_DIV:  ch = CHAR_SLASH;
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/i2p_ram.sv =====
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/infix_to_postfix_converter_core.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter without parentheses: letters pass straight through,
// operators go through an operator stack held in RAM, an end marker flushes.
// ----------------------------------------------------------------------------
// Takes one character per req_ beat and returns postfix characters as rsp_
// beats; run_last marks the last beat caused by a request, expr_done the last
// beat of a flush (a bare beat with has_symbol low when the stack was empty).
// The operator stack lives in a RAM with one registered read port, so each
// pop first reads the top entry. A letter is taken in and passed out when
// decoded; an ignored character is just decoded. An operator on an empty
// stack is decoded and pushed. On a non-empty stack the top is read and
// compared, each operator of equal or higher precedence is popped, and a
// compare that finds a lower one ends the pops before the push. An end marker
// pops every stacked operator. A step that emits waits on rsp_stall. req_stall
// is high while a request is in work. A push onto a full stack is dropped and
// sets overflow_seen until the end of the expression.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_core #(
   parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_end_of_expr,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_symbol_out,
   output logic            rsp_has_symbol,
   output logic            rsp_run_last,
   output logic            rsp_expr_done,
   output logic            rsp_overflow_seen
);

   import i2p_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEC  = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [7:0]       sym_ff, sym_in;
   logic             eoe_ff, eoe_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   op_code_type      pend_ff, pend_in;
   logic             pend_v_ff, pend_v_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_sym_ff;
   logic             rsp_has_ff, rsp_last_ff, rsp_done_ff, rsp_ovf_ff;

   logic             emit;
   logic [7:0]       emit_sym;
   logic             emit_has, emit_last, emit_done;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   op_code_type       top_code;

   logic             out_free;
   op_code_type      cur_op;
   logic [CNT_W-1:0] count_m1, count_m2;
   logic             count_one, count_zero, stack_full;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_op     = op_code_of(sym_ff);
   assign count_m1   = count_ff - CNT_W'(1);
   assign count_m2   = count_ff - CNT_W'(2);
   assign count_one  = (count_ff == CNT_W'(1));
   assign count_zero = (count_ff == '0);
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));

   // Operator stack storage
   i2p_ram #(
      .WIDTH (OP_W),
      .DEPTH (STACK_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(cur_op),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(top_code)
   );

   // Sequencer: decode the request, then pop, push or flush one step a cycle unless the output stalls
   always_comb begin
      state_in    = state_ff;
      sym_in      = sym_ff;
      eoe_in      = eoe_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      emit        = 1'b0;
      emit_sym    = CHAR_NONE;
      emit_has    = 1'b0;
      emit_last   = 1'b0;
      emit_done   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = count_m1[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sym_in   = req_symbol;
               eoe_in   = req_end_of_expr;
               state_in = S_DEC;
            end
         end

         S_DEC: begin
            if (eoe_ff) begin
               if (count_zero) begin
                  // empty flush: one bare closing beat
                  if (out_free) begin
                     emit      = 1'b1;
                     emit_last = 1'b1;
                     emit_done = 1'b1;
                     ovf_in    = 1'b0;
                     state_in  = S_IDLE;
                  end
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = S_CMP;
               end
            end else if (is_letter(sym_ff)) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_sym  = sym_ff;
                  emit_has  = 1'b1;
                  emit_last = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (is_operator(sym_ff)) begin
               if (count_zero) begin
                  state_in = S_FIN;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = S_CMP;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_CMP: begin
            if (eoe_ff) begin
               // flush: pop top, last beat closes the expression
               if (out_free) begin
                  emit      = 1'b1;
                  emit_sym  = op_char(top_code);
                  emit_has  = 1'b1;
                  emit_last = count_one;
                  emit_done = count_one;
                  count_in  = count_m1;
                  if (count_one) begin
                     ovf_in   = 1'b0;
                     state_in = S_IDLE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = count_m2[ADDR_W-1:0];
                  end
               end
            end else if (op_rank(cur_op) <= op_rank(top_code)) begin
               // pop into the pending slot; release the older pending beat
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     emit     = 1'b1;
                     emit_sym = op_char(pend_ff);
                     emit_has = 1'b1;
                  end
                  pend_in   = top_code;
                  pend_v_in = 1'b1;
                  count_in  = count_m1;
                  if (count_one) begin
                     state_in = S_FIN;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = count_m2[ADDR_W-1:0];
                  end
               end
            end else begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            // release the last pending pop, then push or flag overflow
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  emit      = 1'b1;
                  emit_sym  = op_char(pend_ff);
                  emit_has  = 1'b1;
                  emit_last = 1'b1;
               end
               pend_v_in = 1'b0;
               if (stack_full) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the output beat until taken; load a new one when emitted
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      eoe_ff  <= eoe_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_sym_ff  <= emit_sym;
         rsp_has_ff  <= emit_has;
         rsp_last_ff <= emit_last;
         rsp_done_ff <= emit_done;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_symbol_out    = rsp_sym_ff;
   assign rsp_has_symbol    = rsp_has_ff;
   assign rsp_run_last      = rsp_last_ff;
   assign rsp_expr_done     = rsp_done_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/i2p_checker.sv =====
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks for the infix to postfix converter, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_symbol_out,
   input wire logic       rsp_has_symbol,
   input wire logic       rsp_run_last,
   input wire logic       rsp_expr_done,
   input wire logic       rsp_overflow_seen
);

   import i2p_pkg::*;

   // No result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol_out) &&
      $stable(rsp_has_symbol) && $stable(rsp_run_last) &&
      $stable(rsp_expr_done) && $stable(rsp_overflow_seen))
      else $error("stalled result beat changed");

   // Closing beat of an expression is the last beat of its request
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done |-> rsp_run_last)
      else $error("expr_done without run_last");

   // A bare beat only closes an empty flush
   a_bare_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_symbol |->
      rsp_expr_done && (rsp_symbol_out == CHAR_NONE))
      else $error("bare beat outside an empty flush");

   // Emitted characters are letters or operators only
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_symbol |->
      ((rsp_symbol_out >= CHAR_LOW_A) && (rsp_symbol_out <= CHAR_LOW_Z)) ||
      (rsp_symbol_out == CHAR_PLUS) || (rsp_symbol_out == CHAR_MINUS) ||
      (rsp_symbol_out == CHAR_STAR) || (rsp_symbol_out == CHAR_SLASH))
      else $error("emitted character outside letters and operators");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for infix_to_postfix_converter_core. A behavioral
// operator stack predicts every postfix beat per request. The rsp_ side checks
// each beat field by field against the oldest prediction. Directed tests, then
// random expressions; both channels idle at random except in a last batch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import i2p_pkg::*;

   localparam int unsigned STACK_LEVELS = 16;
   localparam int MAX_BEATS   = 16;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 24;

   typedef struct packed {
      logic [7:0] symbol_out;
      logic       has_symbol;
      logic       run_last;
      logic       expr_done;
      logic       overflow_seen;
   } postfix_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_symbol;
   logic       req_end_of_expr;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_symbol_out;
   logic       rsp_has_symbol;
   logic       rsp_run_last;
   logic       rsp_expr_done;
   logic       rsp_overflow_seen;

   // Predictor state: its own operator stack and sticky overflow flag
   op_code_type      op_stack [STACK_LEVELS];
   int               op_count = 0;
   logic             overflow_flag = 1'b0;
   postfix_beat_type pending_postfix [$];

   int  errors       = 0;
   int  beats_sent   = 0;
   int  beats_seen   = 0;
   int  flushes      = 0;
   int  stall_left   = 0;
   logic idle_on     = 1'b0;

   infix_to_postfix_converter_core #(
      .STACK_DEPTH(STACK_LEVELS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .req_end_of_expr   (req_end_of_expr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_symbol_out    (rsp_symbol_out),
      .rsp_has_symbol    (rsp_has_symbol),
      .rsp_run_last      (rsp_run_last),
      .rsp_expr_done     (rsp_expr_done),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Map a stacked operator back to its character
   function automatic logic [7:0] operator_char(input op_code_type code);
      case (code)
         OP_ADD:  return CHAR_PLUS;
         OP_SUB:  return CHAR_MINUS;
         OP_MUL:  return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   // Return 1 and the operator encoding if the character is an operator
   function automatic logic decode_operator(input logic [7:0] ch, output op_code_type code);
      code = OP_ADD;
      case (ch)
         CHAR_PLUS:  code = OP_ADD;
         CHAR_MINUS: code = OP_SUB;
         CHAR_STAR:  code = OP_MUL;
         CHAR_SLASH: code = OP_DIV;
         default:    return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Work out the postfix beats caused by one accepted request
   task automatic predict_postfix(input logic [7:0] sym, input logic eoe);
      postfix_beat_type burst [MAX_BEATS];
      op_code_type      code;
      int               n;
      n = 0;
      if (eoe) begin
         // flush: pop everything, top first
         while (op_count > 0 && n < MAX_BEATS) begin
            op_count--;
            burst[n] = '{operator_char(op_stack[op_count]), 1'b1, 1'b0, 1'b0, overflow_flag};
            n++;
         end
         if (n == 0) begin
            burst[n] = '{CHAR_NONE, 1'b0, 1'b0, 1'b0, overflow_flag};
            n++;
         end
         burst[n-1].expr_done = 1'b1;
         op_count      = 0;
         overflow_flag = 1'b0;
         flushes++;
      end else if (sym >= CHAR_LOW_A && sym <= CHAR_LOW_Z) begin
         burst[n] = '{sym, 1'b1, 1'b0, 1'b0, overflow_flag};
         n++;
      end else if (decode_operator(sym, code)) begin
         // pop equal or higher precedence, then push (drop on a full stack)
         while (op_count > 0 && n < MAX_BEATS && code[1] <= op_stack[op_count-1][1]) begin
            op_count--;
            burst[n] = '{operator_char(op_stack[op_count]), 1'b1, 1'b0, 1'b0, overflow_flag};
            n++;
         end
         if (op_count >= STACK_LEVELS) begin
            overflow_flag = 1'b1;
         end else begin
            op_stack[op_count] = code;
            op_count++;
         end
      end
      if (n > 0) burst[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) pending_postfix.push_back(burst[i]);
   endtask

   // Send one request beat, with an optional idle burst ahead of it
   task automatic send_beat(input logic [7:0] sym, input logic eoe);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_symbol      <= sym;
      req_end_of_expr <= eoe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      predict_postfix(sym, eoe);
   endtask

   function automatic logic [7:0] random_letter();
      return CHAR_LOW_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   // Compare one field; report time, expected and actual
   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Check every accepted rsp_ beat against the oldest prediction
   always @(posedge clock) begin : rsp_check
      postfix_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_postfix.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual symbol_out %h has_symbol %b",
                     $time, rsp_symbol_out, rsp_has_symbol);
            errors++;
         end else begin
            want = pending_postfix.pop_front();
            check_field("symbol_out", want.symbol_out, rsp_symbol_out);
            check_field("has_symbol", 8'(want.has_symbol), 8'(rsp_has_symbol));
            check_field("run_last", 8'(want.run_last), 8'(rsp_run_last));
            check_field("expr_done", 8'(want.expr_done), 8'(rsp_expr_done));
            check_field("overflow_seen", 8'(want.overflow_seen), 8'(rsp_overflow_seen));
            beats_seen++;
         end
      end
   end

   // Random rsp_stall bursts while idling is enabled
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Letters at both ends of the range, then an empty flush
   task automatic test_operands();
      send_beat(CHAR_LOW_A, 1'b0);
      send_beat(CHAR_LOW_Z, 1'b0);
      send_beat(CHAR_NONE, 1'b1);
   endtask

   // Characters just outside the letter range and other junk; end ignores symbol
   task automatic test_ignored();
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CHAR_LOW_A - 8'd1, 1'b0);
      send_beat(CHAR_LOW_Z + 8'd1, 1'b0);
      send_beat("A", 1'b0);
      send_beat(8'hFF, 1'b1);
   endtask

   // All four operators with mixed precedence: a+b*c-d/e
   task automatic test_operators();
      send_beat("a", 1'b0);
      send_beat(CHAR_PLUS, 1'b0);
      send_beat("b", 1'b0);
      send_beat(CHAR_STAR, 1'b0);
      send_beat("c", 1'b0);
      send_beat(CHAR_MINUS, 1'b0);
      send_beat("d", 1'b0);
      send_beat(CHAR_SLASH, 1'b0);
      send_beat("e", 1'b0);
      send_beat(CHAR_LOW_A, 1'b1);
   endtask

   // Operators with nothing to pop, then a two-entry flush
   task automatic test_bare_operators();
      send_beat(CHAR_PLUS, 1'b0);
      send_beat(CHAR_STAR, 1'b0);
      send_beat(CHAR_NONE, 1'b1);
   endtask

   // Mostly well-formed expressions with random content, plus noise and breaks
   task automatic test_random_expressions(input int target);
      int sent;
      int operands;
      sent = 0;
      while (sent < target) begin
         operands = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) begin
            send_beat(random_operator(), 1'b0);
            sent++;
         end
         for (int k = 0; k < operands; k++) begin
            send_beat(random_letter(), 1'b0);
            sent++;
            if ($urandom_range(0, 7) == 0) begin
               send_beat(8'($urandom_range(0, 255)), 1'b0);
               sent++;
            end
            if (k != operands - 1 || $urandom_range(0, 9) == 0) begin
               send_beat(random_operator(), 1'b0);
               sent++;
               if ($urandom_range(0, 11) == 0) begin
                  send_beat(random_operator(), 1'b0);
                  sent++;
               end
            end
         end
         send_beat(8'($urandom_range(0, 255)), 1'b1);
         sent++;
         if ($urandom_range(0, 9) == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int drain;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_symbol      <= CHAR_NONE;
      req_end_of_expr <= 1'b0;
      repeat (2) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      @(posedge clock);

      test_operands();
      test_ignored();
      test_operators();
      test_bare_operators();
      test_random_expressions(60);
      idle_on <= 1'b0;
      test_random_expressions(30);
      req_valid <= 1'b0;

      // Drain outstanding beats, then let the block settle
      drain = 0;
      while (pending_postfix.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (pending_postfix.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_postfix.size());
         errors++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked postfix beats over %0d flushes.",
               beats_sent, beats_seen, flushes);
      $display("Directed operand, junk, precedence and empty-flush cases ran first.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("%0t: watchdog expired", $time);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
